FILE: hdl/ubrp_pkg.sv
`timescale 1ns / 1ps
package ubrp_pkg;

  localparam int TX_AW    = 12;                 // transmit ring, 4096 entries
  localparam int RX_AW    = 8;                  // receive ring, 256 entries
  localparam int PKT_SIZE = 64;                 // bulk max packet size
  localparam int PKT_CW   = $clog2(PKT_SIZE);   // remaining-byte counter
  localparam int PKT_LW   = PKT_CW + 1;         // packet length, 0..PKT_SIZE
  localparam int DROP_W   = 32;

  typedef enum logic [2:0] {
    CMD_WRITE     = 3'd0,
    CMD_READ      = 3'd1,
    CMD_IN_DONE   = 3'd2,
    CMD_OUT_BYTE  = 3'd3,
    CMD_CONFIG    = 3'd4,
    CMD_DECONFIG  = 3'd5,
    CMD_BUS_RESET = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_STATUS     = 3'd0,
    KIND_PKT_BYTE   = 3'd1,
    KIND_ZLP        = 3'd2,
    KIND_READ_BYTE  = 3'd3,
    KIND_READ_EMPTY = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data;
    logic       end_of_call;
  } in_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        data_res;
    logic              last;
    logic              accepted;
    logic              rx_receiving;
    logic [DROP_W-1:0] dropped_total;
    logic [TX_AW-1:0]  tx_level;
  } out_t;

endpackage

FILE: hdl/ubrp_ram.sv
`timescale 1ns / 1ps
module ubrp_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [2**AW];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/usb_bulk_ring_packetizer_core.sv
`timescale 1ns / 1ps
// Bulk endpoint data path for a USB serial port: a transmit ring drained in
// packets of up to 64 bytes and a receive ring filled from the OUT endpoint.
// Input channel: in_item is taken at a clock edge with start high and busy low.
// Result channel: every item yields one or more results on out_item, each
// shown for exactly one cycle with out_valid high; the receiver cannot stall,
// so results are never held back. Status fields reflect the state after the
// whole item and are the same on every result of that item.
// Latency: the first result appears in the cycle after the item is accepted.
// Throughput: an item with a single result leaves busy low, so items can be
// issued every cycle. An item that starts a packet of n bytes streams one
// byte per cycle out of the transmit ring memory (one registered read port);
// busy stays high until the last byte is shown and the next item is taken in
// the cycle that shows the last byte.
// Configuration: cfg_we writes port_enabled; write only while idle.
// Reset (rst_n low, synchronous) clears pointers, flags and the drop count and
// sets port_enabled; ring contents are left as they are.
module usb_bulk_ring_packetizer_core
  import ubrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  localparam logic [RX_AW-1:0] RX_MAX = {RX_AW{1'b1}};
  localparam logic [TX_AW-1:0] TX_MAX = {TX_AW{1'b1}};

  // state registers
  state_t             state_r, state_nxt;
  logic               emit_r, emit_nxt;
  logic [PKT_CW-1:0]  left_r, left_nxt;
  logic [TX_AW-1:0]   send_ptr_r, send_ptr_nxt;
  logic [TX_AW-1:0]   tx_wptr_r, tx_wptr_nxt;
  logic [TX_AW-1:0]   tx_rptr_r, tx_rptr_nxt;
  logic [RX_AW-1:0]   rx_wptr_r, rx_wptr_nxt;
  logic [RX_AW-1:0]   rx_rptr_r, rx_rptr_nxt;
  logic               cfgd_r, cfgd_nxt;
  logic               inflight_r, inflight_nxt;
  logic               paused_r, paused_nxt;
  logic [PKT_LW-1:0]  lpl_r, lpl_nxt;
  logic [PKT_LW-1:0]  opb_r, opb_nxt;
  logic [DROP_W-1:0]  drop_r, drop_nxt;
  logic               en_r;
  kind_t              kind_r, kind_nxt;
  logic               acc_r, acc_nxt;
  logic               fwd_r;
  logic [7:0]         fwd_data_r;

  logic               accept;
  logic               send_go;
  logic [PKT_LW-1:0]  n_pkt;
  logic               tx_we, rx_we;
  logic [TX_AW-1:0]   tx_raddr;
  logic [7:0]         tx_rdata, rx_rdata;
  logic [7:0]         pkt_byte;

  function automatic logic [RX_AW-1:0] rx_free(input logic [RX_AW-1:0] w,
                                               input logic [RX_AW-1:0] r);
    rx_free = RX_MAX - (w - r);
  endfunction

  assign accept = start && !busy;

  // ring memories
  ubrp_ram #(.AW(TX_AW), .DW(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wptr_r),
    .wdata (in_item.data),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  ubrp_ram #(.AW(RX_AW), .DW(8)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wptr_r),
    .wdata (in_item.data),
    .raddr (rx_rptr_r),
    .rdata (rx_rdata)
  );

  // first packet byte is read at the accepting edge, the rest during the burst
  assign tx_raddr = accept ? tx_rptr_r : send_ptr_r;

  // decode one item and work out the state after it
  always_comb begin
    logic [TX_AW-1:0] t_used;
    logic             r_empty;
    logic             drop;
    logic             try_send;
    logic [PKT_LW-1:0] opb_inc;
    t_used       = tx_wptr_r - tx_rptr_r;
    r_empty      = (rx_wptr_r == rx_rptr_r);
    drop         = 1'b0;
    try_send     = 1'b0;
    opb_inc      = opb_r + 1'b1;
    tx_wptr_nxt  = tx_wptr_r;
    tx_rptr_nxt  = tx_rptr_r;
    rx_wptr_nxt  = rx_wptr_r;
    rx_rptr_nxt  = rx_rptr_r;
    cfgd_nxt     = cfgd_r;
    inflight_nxt = inflight_r;
    paused_nxt   = paused_r;
    lpl_nxt      = lpl_r;
    opb_nxt      = opb_r;
    drop_nxt     = drop_r;
    kind_nxt     = KIND_STATUS;
    acc_nxt      = 1'b0;
    tx_we        = 1'b0;
    rx_we        = 1'b0;
    send_go      = 1'b0;
    n_pkt        = '0;
    if (accept) begin
      unique case (in_item.command)
        CMD_WRITE: begin
          if (!en_r || !cfgd_r) begin
            drop = 1'b1;
          end else begin
            if (t_used != TX_MAX) begin
              tx_we       = 1'b1;
              tx_wptr_nxt = tx_wptr_r + 1'b1;
              acc_nxt     = 1'b1;
            end else begin
              drop = 1'b1;
            end
            try_send = in_item.end_of_call;
          end
        end
        CMD_READ: begin
          if (r_empty) begin
            kind_nxt = KIND_READ_EMPTY;
          end else begin
            kind_nxt    = KIND_READ_BYTE;
            rx_rptr_nxt = rx_rptr_r + 1'b1;
          end
          if ((in_item.end_of_call || r_empty) && paused_r && en_r) begin
            paused_nxt = (rx_free(rx_wptr_r, rx_rptr_nxt) < RX_AW'(PKT_SIZE));
          end
        end
        CMD_IN_DONE: begin
          inflight_nxt = 1'b0;
          try_send     = 1'b1;
        end
        CMD_OUT_BYTE: begin
          if (paused_r || !cfgd_r) begin
            drop = 1'b1;
          end else begin
            if (rx_free(rx_wptr_r, rx_rptr_r) != '0) begin
              rx_we       = 1'b1;
              rx_wptr_nxt = rx_wptr_r + 1'b1;
              acc_nxt     = 1'b1;
            end else begin
              drop = 1'b1;
            end
            // close the OUT packet on its last byte or at max size
            if (in_item.end_of_call || opb_inc >= PKT_LW'(PKT_SIZE)) begin
              opb_nxt    = '0;
              paused_nxt = (rx_free(rx_wptr_nxt, rx_rptr_r) < RX_AW'(PKT_SIZE));
            end else begin
              opb_nxt = opb_inc;
            end
          end
        end
        CMD_CONFIG: begin
          cfgd_nxt     = 1'b1;
          inflight_nxt = 1'b0;
          lpl_nxt      = '0;
          paused_nxt   = (rx_free(rx_wptr_r, rx_rptr_r) < RX_AW'(PKT_SIZE));
          try_send     = 1'b1;
        end
        CMD_DECONFIG: begin
          cfgd_nxt = 1'b0;
        end
        CMD_BUS_RESET: begin
          cfgd_nxt     = 1'b0;
          inflight_nxt = 1'b0;
          paused_nxt   = 1'b0;
          lpl_nxt      = '0;
        end
        default: begin
        end
      endcase

      // saturating drop count
      if (drop && drop_r != {DROP_W{1'b1}}) begin
        drop_nxt = drop_r + 1'b1;
      end

      // start one IN packet, or a zero-length packet after a full one
      if (try_send && cfgd_nxt && !inflight_nxt) begin
        if (tx_wptr_nxt == tx_rptr_r) begin
          if (lpl_nxt == PKT_LW'(PKT_SIZE)) begin
            lpl_nxt      = '0;
            inflight_nxt = 1'b1;
            kind_nxt     = KIND_ZLP;
          end
        end else begin
          if ((tx_wptr_nxt - tx_rptr_r) > TX_AW'(PKT_SIZE)) begin
            n_pkt = PKT_LW'(PKT_SIZE);
          end else begin
            n_pkt = PKT_LW'(tx_wptr_nxt - tx_rptr_r);
          end
          lpl_nxt      = n_pkt;
          inflight_nxt = 1'b1;
          tx_rptr_nxt  = tx_rptr_r + TX_AW'(n_pkt);
          send_go      = 1'b1;
        end
      end
    end
  end

  // result sequencer: single result or a packet burst
  always_comb begin
    state_nxt    = state_r;
    left_nxt     = left_r;
    send_ptr_nxt = send_ptr_r;
    emit_nxt     = 1'b0;
    unique case (state_r)
      ST_SEND: begin
        send_ptr_nxt = send_ptr_r + 1'b1;
        left_nxt     = left_r - 1'b1;
        if (left_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (accept) begin
      if (send_go) begin
        state_nxt    = ST_SEND;
        send_ptr_nxt = tx_rptr_r + 1'b1;
        left_nxt     = PKT_CW'(n_pkt - 1'b1);
      end else begin
        state_nxt = ST_IDLE;
        emit_nxt  = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      emit_r     <= 1'b0;
      left_r     <= '0;
      tx_wptr_r  <= '0;
      tx_rptr_r  <= '0;
      rx_wptr_r  <= '0;
      rx_rptr_r  <= '0;
      cfgd_r     <= 1'b0;
      inflight_r <= 1'b0;
      paused_r   <= 1'b0;
      lpl_r      <= '0;
      opb_r      <= '0;
      drop_r     <= '0;
      en_r       <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      emit_r     <= emit_nxt;
      left_r     <= left_nxt;
      tx_wptr_r  <= tx_wptr_nxt;
      tx_rptr_r  <= tx_rptr_nxt;
      rx_wptr_r  <= rx_wptr_nxt;
      rx_rptr_r  <= rx_rptr_nxt;
      cfgd_r     <= cfgd_nxt;
      inflight_r <= inflight_nxt;
      paused_r   <= paused_nxt;
      lpl_r      <= lpl_nxt;
      opb_r      <= opb_nxt;
      drop_r     <= drop_nxt;
      if (cfg_we) begin
        en_r <= cfg_wdata;
      end
    end
  end

  // result payload, loaded per item
  always_ff @(posedge clk) begin
    send_ptr_r <= send_ptr_nxt;
    if (accept) begin
      kind_r <= kind_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // bypass a byte written at the same edge that reads its slot
  always_ff @(posedge clk) begin
    fwd_r      <= tx_we && (tx_wptr_r == tx_raddr);
    fwd_data_r <= in_item.data;
  end

  assign pkt_byte = fwd_r ? fwd_data_r : tx_rdata;

  // drive the result channel
  assign busy      = (state_r == ST_SEND) && (left_r != '0);
  assign out_valid = emit_r || (state_r == ST_SEND);

  always_comb begin
    out_item               = '0;
    out_item.accepted      = acc_r;
    out_item.rx_receiving  = !paused_r;
    out_item.dropped_total = drop_r;
    out_item.tx_level      = tx_wptr_r - tx_rptr_r;
    if (state_r == ST_SEND) begin
      out_item.kind     = KIND_PKT_BYTE;
      out_item.data_res = pkt_byte;
      out_item.last     = (left_r == '0);
    end else begin
      out_item.kind     = kind_r;
      out_item.data_res = (kind_r == KIND_READ_BYTE) ? rx_rdata : 8'd0;
      out_item.last     = 1'b1;
    end
  end

  // every accepted item shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("no result after accepted item");

  // a burst only runs with the IN transfer marked in flight
  a_burst_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> inflight_r)
    else $error("packet burst without transfer in flight");

  // single result and burst never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(emit_r && (state_r == ST_SEND)))
    else $error("single result during packet burst");

  // burst counts down one byte per cycle
  a_burst_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SEND) && (left_r != '0)) |=>
      ((state_r == ST_SEND) && (left_r == PKT_CW'($past(left_r) - 1'b1))))
    else $error("packet burst count skipped");

endmodule

FILE: tb/tb_usb_bulk_ring_packetizer_core.sv
`timescale 1ns / 1ps
module tb_usb_bulk_ring_packetizer_core;
  import ubrp_pkg::*;

  localparam int          TX_DEPTH    = 1 << TX_AW;
  localparam int          RX_DEPTH    = 1 << RX_AW;
  localparam logic [2:0]  CMD_UNUSED  = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t result;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic start     = 1'b0;
  logic busy;
  in_t  in_item   = '0;
  logic out_valid;
  out_t out_item;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b1;

  // typed expectation that travels with the item on offer
  bit   row_typed  = 1'b0;
  out_t row_result = '0;

  int unsigned cycle_cnt  = 0;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int          gap_rate   = 2;
  bit          quiet      = 1'b0;
  out_t        pending_results[$];

  // endpoint state as the block should hold it
  logic [7:0]        tx_mem [TX_DEPTH];
  logic [7:0]        rx_mem [RX_DEPTH];
  logic [TX_AW-1:0]  tx_wp = '0;
  logic [TX_AW-1:0]  tx_rp = '0;
  logic [RX_AW-1:0]  rx_wp = '0;
  logic [RX_AW-1:0]  rx_rp = '0;
  bit                configured = 1'b0;
  bit                in_flight  = 1'b0;
  bit                paused     = 1'b0;
  bit                port_on    = 1'b1;
  int unsigned       last_len   = 0;
  int unsigned       out_bytes  = 0;
  logic [DROP_W-1:0] drops      = '0;

  usb_bulk_ring_packetizer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int rx_room();
    logic [RX_AW-1:0] used;
    used = rx_wp - rx_rp;
    return RX_DEPTH - 1 - int'(used);
  endfunction

  function automatic void count_drop();
    if (drops != '1) drops++;
  endfunction

  // pause the OUT endpoint unless a whole packet fits
  function automatic void rearm_rx();
    paused = (rx_room() < PKT_SIZE);
  endfunction

  // start at most one IN transfer from the transmit ring
  function automatic void launch_packet(ref kind_t kinds[$], ref logic [7:0] vals[$]);
    logic [TX_AW-1:0] level;
    int               n;
    if (!configured || in_flight) return;
    level = tx_wp - tx_rp;
    n = int'(level);
    if (n == 0) begin
      // full packet drained the ring: close the transfer with a zero-length packet
      if (last_len == PKT_SIZE) begin
        last_len  = 0;
        in_flight = 1'b1;
        kinds.push_back(KIND_ZLP);
        vals.push_back(8'h00);
      end
      return;
    end
    if (n > PKT_SIZE) n = PKT_SIZE;
    repeat (n) begin
      kinds.push_back(KIND_PKT_BYTE);
      vals.push_back(tx_mem[tx_rp]);
      tx_rp++;
    end
    last_len  = n;
    in_flight = 1'b1;
  endfunction

  // advance the endpoint by one item and list the results it causes
  function automatic void endpoint_step(input in_t it, ref out_t res[$]);
    kind_t      kinds[$];
    logic [7:0] vals[$];
    logic [TX_AW-1:0] level;
    bit         stored;
    bit         empty;
    out_t       r;
    stored = 1'b0;
    case (it.command)
      CMD_WRITE: begin
        if (!port_on || !configured) begin
          count_drop();
        end else begin
          level = tx_wp - tx_rp;
          if (int'(level) < TX_DEPTH - 1) begin
            tx_mem[tx_wp] = it.data;
            tx_wp++;
            stored = 1'b1;
          end else begin
            count_drop();
          end
          if (it.end_of_call) launch_packet(kinds, vals);
        end
      end
      CMD_READ: begin
        empty = (rx_wp == rx_rp);
        if (empty) begin
          kinds.push_back(KIND_READ_EMPTY);
          vals.push_back(8'h00);
        end else begin
          kinds.push_back(KIND_READ_BYTE);
          vals.push_back(rx_mem[rx_rp]);
          rx_rp++;
        end
        if ((it.end_of_call || empty) && paused && port_on) rearm_rx();
      end
      CMD_IN_DONE: begin
        in_flight = 1'b0;
        launch_packet(kinds, vals);
      end
      CMD_OUT_BYTE: begin
        if (paused || !configured) begin
          count_drop();
        end else begin
          if (rx_room() > 0) begin
            rx_mem[rx_wp] = it.data;
            rx_wp++;
            stored = 1'b1;
          end else begin
            count_drop();
          end
          // an OUT packet ends on end_of_call or at max packet size
          out_bytes++;
          if (it.end_of_call || out_bytes >= PKT_SIZE) begin
            out_bytes = 0;
            rearm_rx();
          end
        end
      end
      CMD_CONFIG: begin
        configured = 1'b1;
        in_flight  = 1'b0;
        last_len   = 0;
        rearm_rx();
        launch_packet(kinds, vals);
      end
      CMD_DECONFIG: begin
        configured = 1'b0;
      end
      CMD_BUS_RESET: begin
        configured = 1'b0;
        in_flight  = 1'b0;
        paused     = 1'b0;
        last_len   = 0;
      end
      default: ;
    endcase
    if (kinds.size() == 0) begin
      kinds.push_back(KIND_STATUS);
      vals.push_back(8'h00);
    end
    foreach (kinds[i]) begin
      r.kind          = kinds[i];
      r.data_res      = vals[i];
      r.last          = (i == kinds.size() - 1);
      r.accepted      = stored;
      r.rx_receiving  = !paused;
      r.dropped_total = drops;
      r.tx_level      = tx_wp - tx_rp;
      res.push_back(r);
    end
  endfunction

  function automatic void compare_field(string name, logic [DROP_W-1:0] want,
                                        logic [DROP_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // check results first, then predict what the item accepted at this edge causes
  always @(posedge clk) begin
    out_t want;
    out_t fresh[$];
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", DROP_W'(want.kind), DROP_W'(out_item.kind));
        compare_field("data_res", DROP_W'(want.data_res), DROP_W'(out_item.data_res));
        compare_field("last", DROP_W'(want.last), DROP_W'(out_item.last));
        compare_field("accepted", DROP_W'(want.accepted), DROP_W'(out_item.accepted));
        compare_field("rx_receiving", DROP_W'(want.rx_receiving),
                      DROP_W'(out_item.rx_receiving));
        compare_field("dropped_total", want.dropped_total, out_item.dropped_total);
        compare_field("tx_level", DROP_W'(want.tx_level), DROP_W'(out_item.tx_level));
      end
    end
    if (rst_n && cfg_we) port_on = cfg_wdata;
    if (rst_n && start && !busy) begin
      fresh.delete();
      endpoint_step(in_item, fresh);
      if (row_typed) pending_results.push_back(row_result);
      else foreach (fresh[i]) pending_results.push_back(fresh[i]);
    end
  end

  // offer one item and hold it until the block takes it
  task automatic push_item(input in_t it, input bit typed = 1'b0, input out_t typed_res = '0);
    if (!quiet && gap_rate != 0 && $urandom_range(1, 8) <= gap_rate) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    in_item    <= it;
    row_typed  <= typed;
    row_result <= typed_res;
    do @(negedge clk); while (busy);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send(logic [2:0] cmd, logic [7:0] d, logic eoc);
    in_t it;
    it.command     = cmd;
    it.data        = d;
    it.end_of_call = eoc;
    push_item(it);
  endtask

  task automatic write_call(int len, bit close);
    for (int i = 0; i < len; i++) send(CMD_WRITE, 8'($urandom), close && i == len - 1);
  endtask

  task automatic out_packet(int len, bit close);
    for (int i = 0; i < len; i++) send(CMD_OUT_BYTE, 8'($urandom), close && i == len - 1);
  endtask

  task automatic read_call(int len);
    for (int i = 0; i < len; i++) send(CMD_READ, 8'($urandom), i == len - 1);
  endtask

  // drop start and wait until every expected result is out
  task automatic settle();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending_results.size() != 0 && waited < 20000);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_port(logic en);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed calls with random content, some bare commands and noise
  task automatic random_call();
    int  pick;
    in_t noise;
    pick = $urandom_range(0, 99);
    if (!quiet) gap_rate = $urandom_range(0, 3);
    if (pick < 28) begin
      if ($urandom_range(0, 5) == 0)
        write_call(PKT_SIZE + $urandom_range(0, 1), $urandom_range(0, 7) != 0);
      else
        write_call($urandom_range(1, 10), $urandom_range(0, 7) != 0);
    end else if (pick < 48) begin
      case ($urandom_range(0, 9))
        0, 1:    out_packet(PKT_SIZE, 1'b1);
        2:       out_packet(PKT_SIZE + $urandom_range(1, 6), 1'b0);
        default: out_packet($urandom_range(1, 10), 1'b1);
      endcase
    end else if (pick < 66) begin
      read_call($urandom_range(1, 12));
    end else if (pick < 80) begin
      send(CMD_IN_DONE, 8'($urandom), 1'($urandom));
    end else if (pick < 90) begin
      send(CMD_CONFIG, 8'($urandom), 1'($urandom));
    end else if (pick < 92) begin
      send(CMD_DECONFIG, 8'($urandom), 1'($urandom));
    end else if (pick < 94) begin
      send(CMD_BUS_RESET, 8'($urandom), 1'($urandom));
    end else begin
      noise = in_t'(12'($urandom));
      push_item(noise);
    end
  endtask

  // typed rows are single results with reception armed and an empty tx ring
  function automatic stim_row_t row(logic [2:0] cmd, logic [7:0] d, logic eoc,
                                    bit typed = 1'b0, kind_t kind = KIND_STATUS,
                                    logic [DROP_W-1:0] dropped = '0);
    stim_row_t r;
    r.item.command       = cmd;
    r.item.data          = d;
    r.item.end_of_call   = eoc;
    r.typed              = typed;
    r.result             = '0;
    r.result.kind        = kind;
    r.result.last        = 1'b1;
    r.result.rx_receiving = 1'b1;
    r.result.dropped_total = dropped;
    return r;
  endfunction

  initial begin
    stim_row_t   rows[$];
    int unsigned base;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unconfigured drops, first packets, reads, deconfigure and bus reset
    rows.push_back(row(CMD_READ,      8'h00, 1'b1, 1'b1, KIND_READ_EMPTY, 0));
    rows.push_back(row(CMD_WRITE,     8'hFF, 1'b1, 1'b1, KIND_STATUS,     1));
    rows.push_back(row(CMD_UNUSED,    8'h55, 1'b1, 1'b1, KIND_STATUS,     1));
    rows.push_back(row(CMD_OUT_BYTE,  8'hA5, 1'b1, 1'b1, KIND_STATUS,     2));
    rows.push_back(row(CMD_IN_DONE,   8'h00, 1'b0, 1'b1, KIND_STATUS,     2));
    rows.push_back(row(CMD_CONFIG,    8'h00, 1'b0, 1'b1, KIND_STATUS,     2));
    rows.push_back(row(CMD_READ,      8'h00, 1'b0, 1'b1, KIND_READ_EMPTY, 2));
    rows.push_back(row(CMD_WRITE,     8'h00, 1'b0));
    rows.push_back(row(CMD_WRITE,     8'hFF, 1'b1));
    rows.push_back(row(CMD_WRITE,     8'h80, 1'b1));
    rows.push_back(row(CMD_IN_DONE,   8'hFF, 1'b1));
    rows.push_back(row(CMD_IN_DONE,   8'h00, 1'b0));
    rows.push_back(row(CMD_OUT_BYTE,  8'h01, 1'b0));
    rows.push_back(row(CMD_OUT_BYTE,  8'hFE, 1'b1));
    rows.push_back(row(CMD_READ,      8'h00, 1'b0));
    rows.push_back(row(CMD_READ,      8'hFF, 1'b1));
    rows.push_back(row(CMD_READ,      8'h00, 1'b1));
    rows.push_back(row(CMD_DECONFIG,  8'h00, 1'b0));
    rows.push_back(row(CMD_WRITE,     8'h3C, 1'b1));
    rows.push_back(row(CMD_OUT_BYTE,  8'h7E, 1'b1));
    rows.push_back(row(CMD_CONFIG,    8'hFF, 1'b1));
    rows.push_back(row(CMD_BUS_RESET, 8'h00, 1'b0));
    rows.push_back(row(CMD_CONFIG,    8'h00, 1'b0));
    rows.push_back(row(CMD_WRITE,     8'h11, 1'b1));
    rows.push_back(row(CMD_CONFIG,    8'h00, 1'b1));
    foreach (rows[i]) push_item(rows[i].item, rows[i].typed, rows[i].result);

    // port disabled: writes drop and reads never resume reception
    set_port(1'b0);
    base = items_sent;
    while (items_sent - base < 15) random_call();

    set_port(1'b1);
    base = items_sent;
    while (items_sent - base < 50) random_call();

    // drain the transmit ring, then a full-size packet followed by a zero-length one
    gap_rate = 1;
    send(CMD_CONFIG, 8'h00, 1'b0);
    repeat (3) send(CMD_IN_DONE, 8'h00, 1'b0);
    write_call(PKT_SIZE, 1'b1);
    send(CMD_IN_DONE, 8'h00, 1'b0);
    send(CMD_IN_DONE, 8'h00, 1'b0);

    // closing stretch without idling
    quiet    = 1'b1;
    gap_rate = 0;
    base = items_sent;
    while (items_sent - base < 15) random_call();

    settle();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
